>>> src/pip_pkg.sv
// Shared constants for the point-in-polygon-with-holes block.
`default_nettype none

package pip_pkg;

    // Default coordinate width (longitude; latitude is one bit narrower).
    localparam int DEF_COORD_WIDTH = 32;

    // A ring needs this many vertices before it can contain the point.
    localparam int MIN_RING = 3;

    // Configuration register indexes.
    localparam int CFG_INDEX_WIDTH = 1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_QUERY_LON = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_QUERY_LAT = 1'b1;

    // Result status codes.
    localparam logic STATUS_OK          = 1'b0;
    localparam logic STATUS_SHORT_OUTER = 1'b1;

endpackage : pip_pkg

`default_nettype wire

>>> src/point_in_polygon_with_holes.sv
// Top level: streaming even-odd point-in-polygon test for a polygon with holes.
// A polygon_last vertex passes the stage 1 and stage 2 registers before it raises m_valid.
// Throughput: one vertex request per cycle while the input is not stalled, set by the multiply/compare pipe.
// Input stalls only while a polygon result waits in the pipe end and the output is full.
// Reset (aresetn low, synchronous): pipe empty, ring state cleared, first ring is outer,
// query point returns to zero.
`default_nettype none

module point_in_polygon_with_holes
    import pip_pkg::*;
#(
    parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,

    // configuration write port
    input  wire logic                              cfg_wr_en,
    input  wire logic [CFG_INDEX_WIDTH-1:0]        cfg_index,
    input  wire logic [COORD_WIDTH-1:0]            cfg_wr_data,

    // vertex request channel
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic signed [COORD_WIDTH-1:0]     s_vertex_lon,
    input  wire logic signed [COORD_WIDTH-2:0]     s_vertex_lat,
    input  wire logic                              s_ring_last,
    input  wire logic                              s_polygon_last,

    // result channel
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_inside_res,
    output logic                                   m_status
);

    // Widths: lon is W, lat is W-1, lon differences W+1, lat differences W,
    // cross products W+1 by W.
    localparam int W  = COORD_WIDTH;
    localparam int XW = W + 1;
    localparam int YW = W;
    localparam int PW = XW + YW;

    // ------------------------------------------------------------------
    // Query point registers
    // ------------------------------------------------------------------
    logic signed [W-1:0] q_lon_reg;
    logic signed [W-2:0] q_lat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_lon_reg <= '0;
            q_lat_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_QUERY_LON: q_lon_reg <= cfg_wr_data;
                CFG_QUERY_LAT: q_lat_reg <= cfg_wr_data[W-2:0];
                default:       q_lon_reg <= q_lon_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipe control
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg;
    logic s2_poly_reg;
    logic m_valid_reg;
    logic stall, advance, accept;

    // Hold the whole pipe only when a polygon result is about to land
    // on an output register that is still occupied.
    assign stall   = s2_valid_reg && s2_poly_reg && m_valid_reg && !m_ready;
    assign advance = !stall;
    assign s_ready = advance;
    assign accept  = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Ring tracking at the accept edge: first vertex, previous vertex,
    // saturating vertex count.
    // ------------------------------------------------------------------
    logic signed [W-1:0] first_lon_reg, prev_lon_reg;
    logic signed [W-2:0] first_lat_reg, prev_lat_reg;
    logic [1:0]          seen_reg, seen_next, seen_after;
    logic                ring_start, ring_end, full;

    assign ring_start = (seen_reg == 2'd0);
    assign ring_end   = s_ring_last || s_polygon_last;

    always_comb begin
        if (ring_start) begin
            seen_after = 2'd1;
        end else if (seen_reg == 2'(MIN_RING)) begin
            seen_after = seen_reg;
        end else begin
            seen_after = seen_reg + 2'd1;
        end
        seen_next = ring_end ? 2'd0 : seen_after;
    end

    assign full = (seen_after == 2'(MIN_RING));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= 2'd0;
        end else if (accept) begin
            seen_reg <= seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            prev_lon_reg <= s_vertex_lon;
            prev_lat_reg <= s_vertex_lat;
            if (ring_start) begin
                first_lon_reg <= s_vertex_lon;
                first_lat_reg <= s_vertex_lat;
            end
        end
    end

    // ------------------------------------------------------------------
    // Edge operands. Edge 0 runs from this vertex to the previous one,
    // edge 1 closes the ring from its first vertex to this one.
    // ------------------------------------------------------------------
    logic signed [W-1:0]  xi [2];
    logic signed [W-1:0]  xj [2];
    logic signed [W-2:0]  yi [2];
    logic signed [W-2:0]  yj [2];
    logic                 straddle [2];
    logic                 edge_en_next [2];
    logic signed [XW-1:0] dql_next [2];
    logic signed [XW-1:0] dxx_next [2];
    logic signed [YW-1:0] dd_next  [2];
    logic signed [YW-1:0] dqa_next [2];

    always_comb begin
        xi[0] = s_vertex_lon;
        yi[0] = s_vertex_lat;
        xj[0] = prev_lon_reg;
        yj[0] = prev_lat_reg;
        xi[1] = ring_start ? s_vertex_lon : first_lon_reg;
        yi[1] = ring_start ? s_vertex_lat : first_lat_reg;
        xj[1] = s_vertex_lon;
        yj[1] = s_vertex_lat;
        for (int e = 0; e < 2; e++) begin
            straddle[e] = (yi[e] > q_lat_reg) != (yj[e] > q_lat_reg);
            dql_next[e] = $signed({q_lon_reg[W-1], q_lon_reg}) - $signed({xi[e][W-1], xi[e]});
            dxx_next[e] = $signed({xj[e][W-1], xj[e]}) - $signed({xi[e][W-1], xi[e]});
            dd_next[e]  = $signed({yj[e][W-2], yj[e]}) - $signed({yi[e][W-2], yi[e]});
            dqa_next[e] = $signed({q_lat_reg[W-2], q_lat_reg}) - $signed({yi[e][W-2], yi[e]});
        end
        edge_en_next[0] = !ring_start && straddle[0];
        edge_en_next[1] = ring_end && straddle[1];
    end

    // ------------------------------------------------------------------
    // Stage 1: differences
    // ------------------------------------------------------------------
    logic signed [XW-1:0] s1_dql_reg [2];
    logic signed [XW-1:0] s1_dxx_reg [2];
    logic signed [YW-1:0] s1_dd_reg  [2];
    logic signed [YW-1:0] s1_dqa_reg [2];
    logic                 s1_en_reg  [2];
    logic                 s1_ring_end_reg, s1_poly_reg, s1_full_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int e = 0; e < 2; e++) begin
                s1_dql_reg[e] <= dql_next[e];
                s1_dxx_reg[e] <= dxx_next[e];
                s1_dd_reg[e]  <= dd_next[e];
                s1_dqa_reg[e] <= dqa_next[e];
                s1_en_reg[e]  <= edge_en_next[e];
            end
            s1_ring_end_reg <= ring_end;
            s1_poly_reg     <= s_polygon_last;
            s1_full_reg     <= full;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: cross products. Left is (xq - xi)(yj - yi), right is
    // (xj - xi)(yq - yi); the sign of (yj - yi) picks the compare direction.
    // ------------------------------------------------------------------
    logic signed [PW-1:0] s2_pl_reg  [2];
    logic signed [PW-1:0] s2_pr_reg  [2];
    logic                 s2_neg_reg [2];
    logic                 s2_en_reg  [2];
    logic                 s2_ring_end_reg, s2_full_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (advance) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int e = 0; e < 2; e++) begin
                s2_pl_reg[e]  <= PW'(s1_dql_reg[e] * s1_dd_reg[e]);
                s2_pr_reg[e]  <= PW'(s1_dxx_reg[e] * s1_dqa_reg[e]);
                s2_neg_reg[e] <= s1_dd_reg[e][YW-1];
                s2_en_reg[e]  <= s1_en_reg[e];
            end
            s2_ring_end_reg <= s1_ring_end_reg;
            s2_poly_reg     <= s1_poly_reg;
            s2_full_reg     <= s1_full_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: crossing decision, ring and polygon bookkeeping, result
    // ------------------------------------------------------------------
    logic parity_reg, parity_next;
    logic outer_inside_reg, outer_inside_next;
    logic outer_short_reg, outer_short_next;
    logic hole_hit_reg, hole_hit_next;
    logic in_outer_reg, in_outer_next;
    logic crossing [2];
    logic parity_new, hit, fire;
    logic inside_next, status_next;
    logic m_inside_reg, m_status_reg;

    assign fire = s2_valid_reg && advance;

    always_comb begin
        for (int e = 0; e < 2; e++) begin
            crossing[e] = s2_en_reg[e] &&
                          (s2_neg_reg[e] ? (s2_pr_reg[e] < s2_pl_reg[e])
                                         : (s2_pl_reg[e] < s2_pr_reg[e]));
        end
        parity_new = parity_reg ^ crossing[0] ^ crossing[1];
        hit        = s2_full_reg && parity_new;

        parity_next       = parity_new;
        outer_inside_next = outer_inside_reg;
        outer_short_next  = outer_short_reg;
        hole_hit_next     = hole_hit_reg;
        in_outer_next     = in_outer_reg;

        // close the ring: record it as outer or as a hole, restart parity
        if (s2_ring_end_reg) begin
            parity_next = 1'b0;
            if (in_outer_reg) begin
                outer_short_next  = !s2_full_reg;
                outer_inside_next = hit;
                in_outer_next     = 1'b0;
            end else begin
                hole_hit_next = hole_hit_reg || hit;
            end
        end

        inside_next = !outer_short_next && outer_inside_next && !hole_hit_next;
        status_next = outer_short_next ? STATUS_SHORT_OUTER : STATUS_OK;

        // polygon done: drop all polygon state, next ring is outer again
        if (s2_poly_reg) begin
            outer_inside_next = 1'b0;
            outer_short_next  = 1'b0;
            hole_hit_next     = 1'b0;
            in_outer_next     = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parity_reg       <= 1'b0;
            outer_inside_reg <= 1'b0;
            outer_short_reg  <= 1'b0;
            hole_hit_reg     <= 1'b0;
            in_outer_reg     <= 1'b1;
            m_valid_reg      <= 1'b0;
        end else begin
            if (fire) begin
                parity_reg       <= parity_next;
                outer_inside_reg <= outer_inside_next;
                outer_short_reg  <= outer_short_next;
                hole_hit_reg     <= hole_hit_next;
                in_outer_reg     <= in_outer_next;
            end
            if (fire && s2_poly_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && s2_poly_reg) begin
            m_inside_reg <= inside_next;
            m_status_reg <= status_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_inside_res = m_inside_reg;
    assign m_status     = m_status_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A short outer ring never reports the point inside.
    a_short_not_inside: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == STATUS_SHORT_OUTER)) |-> !m_inside_res)
        else $error("short outer ring reported inside");

    // Input back-pressure only comes from a full, unread output register.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled without a waiting result");

    // Reset empties the pipe and the output.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (!m_valid_reg && !s1_valid_reg && !s2_valid_reg))
        else $error("pipe not empty after reset");

endmodule : point_in_polygon_with_holes

`default_nettype wire

>>> sim/pip_check_pkg.sv
// Verdict predictor and scoreboard for the point-in-polygon-with-holes testbench.
package pip_check_pkg;
    import pip_pkg::*;

    localparam int CW = DEF_COORD_WIDTH;

    typedef struct packed {
        logic contained;
        logic status;
    } verdict_t;

    class containment_scoreboard;
        longint   query_lon, query_lat;
        longint   first_lon, first_lat, prev_lon, prev_lat;
        int       ring_seen;
        bit       ring_parity, outer_inside, outer_short, hole_hit, on_outer;
        verdict_t verdicts_due[$];
        int       failures, n_checked;
        int       n_vertices, n_verdicts, n_inside, n_short, n_hole_hits;

        function new();
            query_lon = 0;
            query_lat = 0;
            clear_ring();
            outer_inside = 1'b0;
            outer_short  = 1'b0;
            hole_hit     = 1'b0;
            on_outer     = 1'b1;
            failures     = 0;
            n_checked    = 0;
            n_vertices   = 0;
            n_verdicts   = 0;
            n_inside     = 0;
            n_short      = 0;
            n_hole_hits  = 0;
        endfunction

        function void clear_ring();
            first_lon   = 0;
            first_lat   = 0;
            prev_lon    = 0;
            prev_lat    = 0;
            ring_seen   = 0;
            ring_parity = 1'b0;
        endfunction

        function void set_query(logic [CFG_INDEX_WIDTH-1:0] index, logic [CW-1:0] data);
            logic signed [CW-1:0] lon_bits;
            logic signed [CW-2:0] lat_bits;
            lon_bits = data;
            lat_bits = data[CW-2:0];
            if (index == CFG_QUERY_LON) begin
                query_lon = lon_bits;
            end else begin
                query_lat = lat_bits;
            end
        endfunction

        // Exact crossing test: the division is cross-multiplied, order flips when rise < 0.
        function bit crosses_ray(longint xi, longint yi, longint xj, longint yj);
            logic signed [127:0] rise, lhs, rhs, run, drop;
            if ((yi > query_lat) == (yj > query_lat)) return 1'b0;
            rise = yj - yi;
            lhs  = query_lon - xi;
            lhs  = lhs * rise;
            run  = xj - xi;
            drop = query_lat - yi;
            rhs  = run * drop;
            return (rise > 0) ? (lhs < rhs) : (rhs < lhs);
        endfunction

        function void note_vertex(logic signed [CW-1:0] lon, logic signed [CW-2:0] lat,
                                  logic ring_last, logic polygon_last);
            longint   x, y;
            bit       ring_end, full, hit;
            verdict_t v;
            x = lon;
            y = lat;
            ring_end = ring_last || polygon_last;
            n_vertices++;
            if (ring_seen == 0) begin
                first_lon   = x;
                first_lat   = y;
                ring_parity = 1'b0;
                ring_seen   = 1;
            end else begin
                if (crosses_ray(x, y, prev_lon, prev_lat)) ring_parity = !ring_parity;
                if (ring_seen < MIN_RING) ring_seen++;
            end
            prev_lon = x;
            prev_lat = y;
            if (ring_end) begin
                if (crosses_ray(first_lon, first_lat, x, y)) ring_parity = !ring_parity;
                full = ring_seen >= MIN_RING;
                hit  = full && ring_parity;
                if (on_outer) begin
                    outer_short  = !full;
                    outer_inside = hit;
                    on_outer     = 1'b0;
                end else if (hit) begin
                    hole_hit = 1'b1;
                end
                clear_ring();
            end
            if (polygon_last) begin
                v.contained = !outer_short && outer_inside && !hole_hit;
                v.status    = outer_short ? STATUS_SHORT_OUTER : STATUS_OK;
                verdicts_due.push_back(v);
                n_verdicts++;
                if (v.contained) n_inside++;
                if (outer_short) n_short++;
                if (outer_inside && hole_hit) n_hole_hits++;
                outer_inside = 1'b0;
                outer_short  = 1'b0;
                hole_hit     = 1'b0;
                on_outer     = 1'b1;
            end
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= 10) $display("%0t: %s", $time, msg);
        endfunction

        function void check_result(logic in_poly, logic status);
            verdict_t want;
            if (verdicts_due.size() == 0) begin
                flag($sformatf("unexpected result inside=%0b status=%0b", in_poly, status));
                return;
            end
            want = verdicts_due.pop_front();
            if (in_poly !== want.contained)
                flag($sformatf("result %0d: inside expected %0b, got %0b",
                               n_checked, want.contained, in_poly));
            if (status !== want.status)
                flag($sformatf("result %0d: status expected %0b, got %0b",
                               n_checked, want.status, status));
            n_checked++;
        endfunction

        function void check_drained();
            if (verdicts_due.size() != 0)
                flag($sformatf("%0d expected results never arrived", verdicts_due.size()));
        endfunction
    endclass

endpackage : pip_check_pkg

>>> sim/tb_point_in_polygon_with_holes.sv
// Testbench top: random and directed polygons streamed against a self-checking scoreboard.
module tb_point_in_polygon_with_holes;
    timeunit 1ns;
    timeprecision 1ps;

    import pip_pkg::*;
    import pip_check_pkg::*;

    localparam int LATENCY        = 3;
    localparam int CYCLE_LIMIT    = 400_000;
    localparam int LONG_HOLD      = 300;
    localparam int PHASE_VERTICES = 70;
    localparam int PHASES         = 6;

    typedef struct {
        logic [CW-1:0] lon;
        logic [CW-2:0] lat;
        logic          ring_last;
        logic          polygon_last;
    } vertex_t;

    logic                       aclk           = 1'b0;
    logic                       aresetn        = 1'b0;
    logic                       cfg_wr_en      = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index      = CFG_QUERY_LON;
    logic [CW-1:0]              cfg_wr_data    = '0;
    logic                       s_valid        = 1'b0;
    logic signed [CW-1:0]       s_vertex_lon   = '0;
    logic signed [CW-2:0]       s_vertex_lat   = '0;
    logic                       s_ring_last    = 1'b0;
    logic                       s_polygon_last = 1'b0;
    logic                       m_ready        = 1'b0;
    logic                       s_ready;
    logic                       m_valid;
    logic                       m_inside_res;
    logic                       m_status;

    containment_scoreboard sb = new();

    vertex_t       poly_q[$];   // polygon under construction, sent whole
    logic [CW-1:0] q_lon;       // query point as last written, latitude sign-extended
    logic [CW-1:0] q_lat;
    bit            offering;    // s_valid currently high
    bit            send_calm;   // no gaps between requests
    bit            recv_calm;   // no stalls on the result side
    bit            long_hold;   // ask the receiver for one long hold-off
    int            stall_left;
    int            cycles;
    int            n_settings;
    int            n_polygons;

    point_in_polygon_with_holes #(
        .COORD_WIDTH(CW)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_vertex_lon  (s_vertex_lon),
        .s_vertex_lat  (s_vertex_lat),
        .s_ring_last   (s_ring_last),
        .s_polygon_last(s_polygon_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_inside_res  (m_inside_res),
        .m_status      (m_status)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog: end a hung run as a failure.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, sb.verdicts_due.size());
            $display("** point_in_polygon_with_holes: FAILED **");
            $finish;
        end
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int idle_cycles(bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    // Signed offset in [-span, span], wrapping at the coordinate width.
    function automatic logic [CW-1:0] jitter(int unsigned span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    // Result side: check what the edge accepted, then pick the next ready level.
    // The long hold-off is counted here so the sender keeps pushing meanwhile.
    always @(posedge aclk) begin
        int n;
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_result(m_inside_res, m_status);
            if (long_hold) begin
                long_hold  = 1'b0;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                n = idle_cycles(recv_calm);
                if (n == 0) begin
                    m_ready <= 1'b1;
                end else begin
                    stall_left = n - 1;
                    m_ready <= 1'b0;
                end
            end
        end
    end

    // Write both query registers on consecutive edges; hold the enable across them.
    task automatic write_query(logic [CW-1:0] lon, logic [CW-1:0] lat_raw);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_QUERY_LON;
        cfg_wr_data <= lon;
        @(posedge aclk);
        sb.set_query(CFG_QUERY_LON, lon);
        cfg_index   <= CFG_QUERY_LAT;
        cfg_wr_data <= lat_raw;
        @(posedge aclk);
        sb.set_query(CFG_QUERY_LAT, lat_raw);
        cfg_wr_en <= 1'b0;
        q_lon = lon;
        q_lat = {lat_raw[CW-2], lat_raw[CW-2:0]};
        n_settings++;
    endtask

    // Present one vertex request and hold it until accepted. Raise valid only when
    // it is low, so that back-to-back requests never toggle it within one step.
    task automatic offer_vertex(vertex_t v);
        int gap;
        gap = idle_cycles(send_calm);
        if (gap > 0) begin
            if (offering) s_valid <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(posedge aclk);
        end
        if (!offering) s_valid <= 1'b1;
        offering = 1'b1;
        s_vertex_lon   <= v.lon;
        s_vertex_lat   <= v.lat;
        s_ring_last    <= v.ring_last;
        s_polygon_last <= v.polygon_last;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_vertex(v.lon, v.lat, v.ring_last, v.polygon_last);
    endtask

    task automatic quiet_sender();
        if (offering) s_valid <= 1'b0;
        offering = 1'b0;
    endtask

    task automatic add_vertex(logic [CW-1:0] lon, logic [CW-1:0] lat);
        vertex_t v;
        v.lon          = lon;
        v.lat          = lat[CW-2:0];
        v.ring_last    = 1'b0;
        v.polygon_last = 1'b0;
        poly_q.push_back(v);
    endtask

    task automatic close_ring();
        poly_q[poly_q.size()-1].ring_last = 1'b1;
    endtask

    // Axis-aligned box around (cx, cy), random half-sizes, start corner and winding.
    task automatic add_box(logic [CW-1:0] cx, logic [CW-1:0] cy, int unsigned span);
        logic [CW-1:0] xs[4];
        logic [CW-1:0] ys[4];
        int unsigned   w0, w1, h0, h1, start;
        bit            ccw;
        int            k;
        w0 = $urandom_range(1, span);
        w1 = $urandom_range(1, span);
        h0 = $urandom_range(1, span);
        h1 = $urandom_range(1, span);
        xs[0] = cx - w0; ys[0] = cy - h0;
        xs[1] = cx + w1; ys[1] = cy - h0;
        xs[2] = cx + w1; ys[2] = cy + h1;
        xs[3] = cx - w0; ys[3] = cy + h1;
        start = $urandom_range(0, 3);
        ccw   = 1'($urandom_range(0, 1));
        for (int i = 0; i < 4; i++) begin
            k = ccw ? (start + i) % 4 : (start + 4 - i) % 4;
            add_vertex(xs[k], ys[k]);
        end
    endtask

    // Scattered ring near the query; some vertices sit exactly on its latitude.
    task automatic add_scatter(int n, int unsigned span);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 7) == 0) add_vertex(q_lon + jitter(span), q_lat);
            else add_vertex(q_lon + jitter(span), q_lat + jitter(span));
        end
    endtask

    task automatic add_noise(int n);
        for (int i = 0; i < n; i++) add_vertex($urandom, $urandom);
    endtask

    // Mark the polygon end on the last vertex, with or without the ring flag, and send.
    task automatic send_polygon(bit ring_flag);
        poly_q[poly_q.size()-1].polygon_last = 1'b1;
        poly_q[poly_q.size()-1].ring_last    = ring_flag;
        foreach (poly_q[i]) offer_vertex(poly_q[i]);
        poly_q.delete();
        n_polygons++;
    endtask

    // Mostly well-formed outer rings around the query with a few holes; the rest are
    // short rings and rings of raw random coordinates.
    task automatic random_polygon();
        int unsigned span, kind, holes;
        span = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32'h4000_0000)
                                           : $urandom_range(1, 4000);
        kind = $urandom_range(0, 9);
        if (kind < 5) add_box(q_lon, q_lat, span);
        else if (kind < 8) add_scatter($urandom_range(3, 7), span);
        else if (kind == 8) add_scatter($urandom_range(1, 2), span);
        else add_noise($urandom_range(1, 6));
        holes = $urandom_range(0, 3);
        for (int h = 0; h < holes; h++) begin
            close_ring();
            case ($urandom_range(0, 4))
                0, 1: begin
                    add_box(q_lon, q_lat, span / 2 + 1);
                end
                2: begin
                    add_box(q_lon + 3 * span + 1, q_lat, span / 2 + 1);
                end
                3: begin
                    add_scatter($urandom_range(3, 6), span);
                end
                default: begin
                    add_scatter($urandom_range(1, 2), span);
                end
            endcase
        end
        send_polygon(1'($urandom_range(0, 1)));
    endtask

    // Hold the result side for a long stretch and keep streaming tiny polygons
    // so the pipe fills and the block has to stall requests.
    task automatic fill_burst();
        long_hold = 1'b1;
        send_calm = 1'b1;
        recv_calm = 1'b0;
        repeat (24) begin
            if ($urandom_range(0, 1)) add_vertex(q_lon + jitter(50), q_lat + jitter(50));
            else add_box(q_lon, q_lat, 50);
            send_polygon(1'($urandom_range(0, 1)));
        end
        send_calm = 1'b0;
    endtask

    // Drop valid, wait for every expected result, then let the pipe settle.
    task automatic drain();
        quiet_sender();
        while (sb.verdicts_due.size() != 0) @(posedge aclk);
        repeat (LATENCY + 2) @(posedge aclk);
    endtask

    initial begin
        int            target;
        logic [CW-1:0] lon, lat;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, query at the origin.
        write_query('0, '0);
        // lone vertex: outer ring too short
        add_vertex(5, 5);
        send_polygon(1'b0);
        // two vertices, ring and polygon end together: still too short
        add_vertex(-10, -10);
        add_vertex(10, 10);
        send_polygon(1'b1);
        // box on the coordinate extremes, ended by the polygon flag alone
        add_vertex(-1800000000, -900000000);
        add_vertex(1800000000, -900000000);
        add_vertex(1800000000, 900000000);
        add_vertex(-1800000000, 900000000);
        send_polygon(1'b0);
        // hole around the query cancels the outer ring
        add_box(q_lon, q_lat, 100);
        close_ring();
        add_box(q_lon, q_lat, 50);
        send_polygon(1'b1);
        // short hole is ignored; a hole beside the query with a vertex on its latitude
        add_box(q_lon, q_lat, 100);
        close_ring();
        add_vertex(-3, -3);
        add_vertex(3, 3);
        close_ring();
        add_vertex(20, 0);
        add_vertex(40, -10);
        add_vertex(40, 10);
        send_polygon(1'b0);
        drain();

        // Random phases, one query point each: both extremes first, then random ones.
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    write_query(1800000000, 900000000);
                end
                1: begin
                    write_query(-1800000000, -900000000);
                end
                default: begin
                    if ($urandom_range(0, 3) == 0) begin
                        write_query($urandom, $urandom);
                    end else begin
                        lon = $urandom_range(0, 32'd3600000000) - 32'd1800000000;
                        lat = $urandom_range(0, 32'd1800000000) - 32'd900000000;
                        lat[CW-1] = 1'($urandom_range(0, 1));
                        write_query(lon, lat);
                    end
                end
            endcase
            if (phase == 3) fill_burst();
            target = sb.n_vertices + PHASE_VERTICES;
            while (sb.n_vertices < target) begin
                send_calm = ($urandom_range(0, 5) == 0);
                recv_calm = ($urandom_range(0, 5) == 0);
                random_polygon();
            end
            drain();
        end

        repeat (10) @(posedge aclk);
        sb.check_drained();
        $display("Streamed %0d vertices in %0d polygons over %0d query points, one %0d-cycle hold-off.",
                 sb.n_vertices, n_polygons, n_settings, LONG_HOLD);
        $display("Verdicts: %0d inside, %0d outside, %0d short outer rings, %0d cleared by a hole.",
                 sb.n_inside, sb.n_verdicts - sb.n_inside, sb.n_short, sb.n_hole_hits);
        if (sb.failures == 0) begin
            $display("** point_in_polygon_with_holes: PASSED **");
        end else begin
            $display("%0d failures", sb.failures);
            $display("** point_in_polygon_with_holes: FAILED **");
        end
        $finish;
    end

endmodule : tb_point_in_polygon_with_holes
